/* rtl/llq_pkg.sv */
`timescale 1ns / 1ps
// Package for the linked-list queue with free list.
// Holds default sizes, operation and status codes and the control state type.
// No dependencies.
package llq_pkg;

  // Default sizing
  localparam int NODE_COUNT_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Width of value fields on the stream ports
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Operation codes carried on s_tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // Status codes carried on m_tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Control sequencer, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

/* rtl/linked_list_queue_free_list.sv */
`timescale 1ns / 1ps
// FIFO kept as a singly linked list in a node store, unused nodes on a free list.
// Link and data stores are synchronous memories inside this module.
// Depends on llq_pkg.
//
//  port group | dir | tdata                     | tuser
//  s_*        | in  | [31:0] value (signed)     | [0] operation (0 insert, 1 delete)
//  m_*        | out | [31:0] result_value (sgn) | [1:0] status (0 done,1 full,2 empty)
//
// The accept edge issues the registered read of the link and data memories; the
// execute step that follows writes at most one link (and the data on an insert)
// and updates the head, tail and free-list pointers. No word is taken meanwhile.
// Reset (rst, synchronous) needs no clearing pass: a fill count marks links not
// yet written, which read as the initial chain i -> i+1.
// A word is taken only while the result register is empty or being drained.
module linked_list_queue_free_list #(
  parameter int NODE_COUNT = llq_pkg::NODE_COUNT_DEF,
  parameter int DATA_WIDTH = llq_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic signed [llq_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
  input  logic                               s_tuser,   // [0] operation
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic signed [llq_pkg::VALUE_W-1:0] m_tdata,   // [31:0] result_value
  output logic [llq_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);

  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LINK_W = $clog2(NODE_COUNT + 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NODE_COUNT);

  // Memories
  logic [LINK_W-1:0]     next_mem [NODE_COUNT];
  logic [DATA_WIDTH-1:0] data_mem [NODE_COUNT];

  // Control and pointer registers
  llq_pkg::state_t   state, state_next;
  logic [LINK_W-1:0] free_head, free_head_next;
  logic [LINK_W-1:0] list_head, list_head_next;
  logic [LINK_W-1:0] list_tail, list_tail_next;
  logic [LINK_W-1:0] fill, fill_next;

  // Latched word and read address
  logic                               op_q;
  logic signed [llq_pkg::VALUE_W-1:0] value_q;
  logic [LINK_W-1:0]                  rd_addr_q;
  logic [LINK_W-1:0]                  rd_addr;
  logic [LINK_W-1:0]                  next_q;
  logic [DATA_WIDTH-1:0]              data_q;

  // Link write port
  logic              nx_we;
  logic [LINK_W-1:0] nx_wa;
  logic [LINK_W-1:0] nx_wd;
  logic              dt_we;

  // Result loading
  logic                               out_load;
  logic [llq_pkg::STATUS_W-1:0]       out_status;
  logic signed [llq_pkg::VALUE_W-1:0] out_value;

  logic              s_acc;
  logic [LINK_W-1:0] link_rd;
  logic signed [63:0] store_ext;
  logic signed [63:0] load_ext;

  assign s_tready = (state == llq_pkg::S_IDLE) && (!m_tvalid || m_tready);
  assign s_acc    = s_tvalid && s_tready;

  // Read address: free-list head for insert, queue head for delete
  assign rd_addr = (s_tuser == llq_pkg::OP_DELETE) ? list_head : free_head;

  // Synchronous reads at the accept edge
  always_ff @(posedge clk) begin
    if (s_acc) begin
      next_q    <= next_mem[rd_addr[ADDR_W-1:0]];
      data_q    <= data_mem[rd_addr[ADDR_W-1:0]];
      rd_addr_q <= rd_addr;
      op_q      <= s_tuser;
      value_q   <= s_tdata;
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa[ADDR_W-1:0]] <= nx_wd;
    end
    if (dt_we) begin
      data_mem[free_head[ADDR_W-1:0]] <= store_ext[DATA_WIDTH-1:0];
    end
  end

  // Links at or past the fill count were never written: they hold i + 1
  assign link_rd = (rd_addr_q >= fill) ? LINK_W'(rd_addr_q + 1'b1) : next_q;

  // Width conversion between the port and the stored value
  assign store_ext = 64'(value_q);
  assign load_ext  = 64'($signed(data_q));

  // Execute step: pointer updates, the data write and at most one link write
  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    list_head_next = list_head;
    list_tail_next = list_tail;
    fill_next      = fill;
    nx_we          = 1'b0;
    nx_wa          = list_tail;
    nx_wd          = free_head;
    dt_we          = 1'b0;
    out_load       = 1'b0;
    out_status     = llq_pkg::ST_DONE;
    out_value      = value_q;
    unique case (state)
      llq_pkg::S_IDLE: begin
        if (s_acc) begin
          state_next = llq_pkg::S_EXEC;
        end
      end
      llq_pkg::S_EXEC: begin
        state_next = llq_pkg::S_IDLE;
        out_load   = 1'b1;
        if (op_q == llq_pkg::OP_INSERT) begin
          if (free_head == LINK_NULL) begin
            out_status = llq_pkg::ST_FULL;
          end else begin
            dt_we          = 1'b1;
            free_head_next = link_rd;
            if (free_head == fill) begin
              fill_next = fill + 1'b1;
            end
            // append after the tail, or start a new queue
            if (list_head == LINK_NULL || list_tail == LINK_NULL) begin
              list_head_next = free_head;
            end else begin
              nx_we = 1'b1;
              nx_wa = list_tail;
              nx_wd = free_head;
            end
            list_tail_next = free_head;
          end
        end else begin
          if (list_head == LINK_NULL) begin
            out_status = llq_pkg::ST_EMPTY;
            out_value  = '0;
          end else begin
            out_value = load_ext[llq_pkg::VALUE_W-1:0];
            // push the removed node onto the free list
            nx_we          = 1'b1;
            nx_wa          = list_head;
            nx_wd          = free_head;
            free_head_next = list_head;
            // the tail's stored link is stale; treat it as null
            if (list_head == list_tail) begin
              list_head_next = LINK_NULL;
              list_tail_next = LINK_NULL;
            end else begin
              list_head_next = link_rd;
            end
          end
        end
      end
      default: begin
        state_next = llq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= llq_pkg::S_IDLE;
      free_head <= '0;
      list_head <= LINK_NULL;
      list_tail <= LINK_NULL;
      fill      <= '0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      list_head <= list_head_next;
      list_tail <= list_tail_next;
      fill      <= fill_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_value;
      m_tuser <= out_status;
    end
  end

  // Assertions
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= LINK_W'(NODE_COUNT))
    else $error("fill count past node count");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (list_head == LINK_NULL) == (list_tail == LINK_NULL))
    else $error("head and tail disagree on empty queue");

  a_free_vs_head: assert property (@(posedge clk) disable iff (rst)
    list_head != LINK_NULL |-> free_head != list_head)
    else $error("node both queued and free");

  a_exec_slot: assert property (@(posedge clk) disable iff (rst)
    state == llq_pkg::S_EXEC |-> !m_tvalid)
    else $error("result register busy at execute");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    state == llq_pkg::S_EXEC |=> m_tvalid && state == llq_pkg::S_IDLE)
    else $error("execute step gave no result");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for linked_list_queue_free_list: directed and random insert/delete words,
// predicted against an in-bench linked-list model, with random gaps on both streams.
// Depends on llq_pkg and the linked_list_queue_free_list RTL.
module testbench;

  localparam int NODES       = llq_pkg::NODE_COUNT_DEF;
  localparam int DATA_W      = llq_pkg::DATA_WIDTH_DEF;
  localparam int LINK_W      = $clog2(NODES + 1);
  localparam int TOTAL_WORDS = 1750;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 20;

  typedef logic [LINK_W-1:0] link_t;
  localparam link_t NIL = link_t'(NODES);

  typedef struct {
    llq_pkg::op_t                op;
    logic [llq_pkg::VALUE_W-1:0] value;
  } op_word_t;

  typedef struct {
    llq_pkg::status_t                   status;
    logic signed [llq_pkg::VALUE_W-1:0] value;
  } queue_result_t;

  // Clock, reset and stream signals; the bench-driven ones are known from time zero
  logic                               clk      = 1'b0;
  logic                               rst      = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic signed [llq_pkg::VALUE_W-1:0] s_tdata  = '0;   // [31:0] value
  logic                               s_tuser  = 1'b0; // [0] operation
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic signed [llq_pkg::VALUE_W-1:0] m_tdata;         // [31:0] result_value
  logic [llq_pkg::STATUS_W-1:0]       m_tuser;         // [1:0] status

  // Words waiting to be sent, results waiting to come back
  op_word_t      op_words[$];
  queue_result_t due_results[$];

  // Shadow copy of the node store and its pointers
  logic signed [DATA_W-1:0] node_data[NODES];
  link_t                    node_next[NODES];
  link_t                    free_head;
  link_t                    list_head;
  link_t                    list_tail;

  int          errors   = 0;
  int          quiet    = 0;
  int          send_gap = 0;
  int          take_gap = 0;
  logic [31:0] cycle_no = '0;
  logic        calm;

  always #2 clk = ~clk;

  linked_list_queue_free_list DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // One window in four runs with no idling at all
  assign calm = (cycle_no[9:8] == 2'b00);

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  // Apply one word to the shadow queue and return the result it produces
  function automatic queue_result_t queue_step(llq_pkg::op_t op,
                                               logic [llq_pkg::VALUE_W-1:0] value);
    queue_result_t r;
    link_t         node;
    link_t         nxt;
    r.status = llq_pkg::ST_DONE;
    r.value  = value;
    if (op == llq_pkg::OP_INSERT) begin
      node = free_head;
      if (node >= NODES) begin
        r.status = llq_pkg::ST_FULL;
      end else begin
        free_head       = node_next[node];
        node_data[node] = value[DATA_W-1:0];
        node_next[node] = NIL;
        if (list_head >= NODES || list_tail >= NODES) begin
          list_head = node;
        end else begin
          node_next[list_tail] = node;
        end
        list_tail = node;
      end
    end else begin
      node = list_head;
      if (node >= NODES) begin
        r.status = llq_pkg::ST_EMPTY;
        r.value  = '0;
      end else begin
        // signed store widens with sign extension
        r.value = node_data[node];
        nxt     = node_next[node];
        if (nxt >= NODES) nxt = NIL;
        node_next[node] = free_head;
        free_head       = node;
        list_head       = nxt;
        if (nxt == NIL) list_tail = NIL;
      end
    end
    return r;
  endfunction

  function automatic logic [llq_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 85) return $urandom_range(0, 31);
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  task automatic add_word(input llq_pkg::op_t op, input logic [llq_pkg::VALUE_W-1:0] value);
    op_word_t w;
    w.op    = op;
    w.value = value;
    op_words.push_back(w);
  endtask

  // Driver: next word once the current one is taken and any gap has run out
  always @(posedge clk) begin
    op_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap != 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (op_words.size() != 0) begin
        w = op_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= w.value;
        s_tuser  <= w.op;
        send_gap <= idle_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: may stall after a taken word, and sometimes while waiting
  always @(posedge clk) begin
    int   hold;
    logic ready_next;
    hold       = 0;
    ready_next = 1'b1;
    if (rst) begin
      ready_next = 1'b0;
    end else if (take_gap != 0) begin
      ready_next = 1'b0;
      hold       = take_gap - 1;
    end else if (m_tvalid && m_tready) begin
      hold       = idle_len();
      ready_next = (hold == 0);
      if (hold != 0) hold = hold - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      ready_next = 1'b0;
    end
    m_tready <= ready_next;
    take_gap <= hold;
  end

  // Monitor: check results in order, predict on each accepted word, watchdog
  always @(posedge clk) begin
    queue_result_t exp_r;
    logic          moved;
    moved = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d value=%h",
                                    m_tuser, m_tdata));
        end else begin
          exp_r = due_results.pop_front();
          if (m_tuser !== exp_r.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      m_tuser, exp_r.status));
          if (m_tdata !== exp_r.value)
            report_mismatch($sformatf("result_value got %h want %h",
                                      m_tdata, exp_r.value));
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        due_results.push_back(queue_step(llq_pkg::op_t'(s_tuser), s_tdata));
      end
    end
    if (moved) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int  phase_left;
    int  insert_pct;
    int  i;
    // shadow state after reset: free chain 0 -> 1 -> ... -> null
    for (i = 0; i < NODES; i++) begin
      node_data[i] = '0;
      node_next[i] = link_t'(i + 1);
    end
    free_head = '0;
    list_head = NIL;
    list_tail = NIL;

    // Directed: delete on empty, extreme values, drain to empty, delete ignores value
    add_word(llq_pkg::OP_DELETE, $urandom);
    add_word(llq_pkg::OP_INSERT, 32'h8000_0000);
    add_word(llq_pkg::OP_INSERT, 32'h7FFF_FFFF);
    add_word(llq_pkg::OP_INSERT, 32'h0000_0000);
    add_word(llq_pkg::OP_INSERT, 32'hFFFF_FFFF);
    add_word(llq_pkg::OP_INSERT, 32'h5555_5555);
    add_word(llq_pkg::OP_INSERT, 32'hAAAA_AAAA);
    add_word(llq_pkg::OP_INSERT, 32'h0000_0001);
    for (i = 0; i < 7; i++) add_word(llq_pkg::OP_DELETE, $urandom);
    add_word(llq_pkg::OP_DELETE, 32'hFFFF_FFFF);
    add_word(llq_pkg::OP_INSERT, 32'h1234_5678);
    add_word(llq_pkg::OP_DELETE, 32'hFFFF_FFFF);
    add_word(llq_pkg::OP_DELETE, $urandom);
    add_word(llq_pkg::OP_INSERT, $urandom);

    // Random: fill-heavy and drain-heavy phases so full and empty recur often
    phase_left = 0;
    insert_pct = 50;
    while (op_words.size() < TOTAL_WORDS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 48);
        case ($urandom_range(0, 4))
          0, 1:    insert_pct = 80;
          2, 3:    insert_pct = 20;
          default: insert_pct = 50;
        endcase
      end
      phase_left--;
      if ($urandom_range(0, 99) < insert_pct) add_word(llq_pkg::OP_INSERT, pick_value());
      else add_word(llq_pkg::OP_DELETE, $urandom);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // sample between edges so the driver and monitor have settled
    while (op_words.size() != 0 || s_tvalid || due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/llq_pkg.sv
rtl/linked_list_queue_free_list.sv
tb/testbench.sv
